// ===== design/hew_pkg.sv =====
`default_nettype none
package hew_pkg;
   localparam int TableLen = 24;
   localparam int HalfTurn = 11520;
   localparam int FullTurn = 23040;
   // 33 bits for east/north, shifted 24 up, plus growth room
   localparam int VecW = 58;
   localparam int AngW = 34;

   typedef logic signed [VecW-1:0] vec_type;
   typedef logic signed [AngW-1:0] ang_type;

   // atan(2^-i) in degrees * 2^22
   function automatic ang_type atan_entry(input logic [4:0] idx);
      ang_type v;
      case (idx)
         5'd0: v = 34'sd188743680;
         5'd1: v = 34'sd111421900;
         5'd2: v = 34'sd58872272;
         5'd3: v = 34'sd29884485;
         5'd4: v = 34'sd15000234;
         5'd5: v = 34'sd7507429;
         5'd6: v = 34'sd3754631;
         5'd7: v = 34'sd1877430;
         5'd8: v = 34'sd938729;
         5'd9: v = 34'sd469366;
         5'd10: v = 34'sd234683;
         5'd11: v = 34'sd117342;
         5'd12: v = 34'sd58671;
         5'd13: v = 34'sd29335;
         5'd14: v = 34'sd14668;
         5'd15: v = 34'sd7334;
         5'd16: v = 34'sd3667;
         5'd17: v = 34'sd1833;
         5'd18: v = 34'sd917;
         5'd19: v = 34'sd458;
         5'd20: v = 34'sd229;
         5'd21: v = 34'sd115;
         5'd22: v = 34'sd57;
         5'd23: v = 34'sd29;
         default: v = '0;
      endcase
      return v;
   endfunction

   typedef struct packed {
      logic       zero;
      logic signed [15:0] comp;
   } side_type;
endpackage
`default_nettype wire

// ===== design/heading_error_to_waypoint.sv =====
// Registers from request accept to result valid: stage 0, stage 1, one per CORDIC step, and the output register.
// Throughput: one request per cycle while the result side does not stall; one CORDIC iteration per pipeline stage.
// A stall on the result side holds the whole pipeline in place.
// Reset clears the valid bits only; the data path has no reset.
`default_nettype none
module heading_error_to_waypoint #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_fix_valid,
   input  wire logic signed [29:0] req_current_lat,
   input  wire logic signed [30:0] req_current_lon,
   input  wire logic signed [29:0] req_target_lat,
   input  wire logic signed [30:0] req_target_lon,
   input  wire logic [14:0]        req_heading,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [14:0]      rsp_turn_error
);
   localparam int Steps = (CORDIC_STEPS < hew_pkg::TableLen) ? CORDIC_STEPS
                                                           : hew_pkg::TableLen;
   localparam int Depth = Steps + 3;

   logic enable;
   logic [Depth-1:0] vld_ff;
   logic [Depth-1:0] vld_in;

   assign enable = !rsp_valid || rsp_ready;
   assign req_ready = enable;
   assign vld_in = {vld_ff[Depth-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= vld_in;
      end
   end
   assign rsp_valid = vld_ff[Depth-1];

   // stage 0: east as the negated sum of the longitudes, north difference, and heading fold
   // east spans up to 2^31 in magnitude, so it takes 33 bits, two more than the longitude inputs
   logic signed [32:0] east_ff, north_ff;
   hew_pkg::side_type side0_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         east_ff  <= -33'(req_target_lon) - 33'(req_current_lon);
         north_ff <= 33'(req_target_lat) - 33'(req_current_lat);
         side0_ff.zero <= !req_fix_valid;
         side0_ff.comp <= (req_heading > 15'(hew_pkg::HalfTurn))
            ? 16'(signed'({1'b0, req_heading}) - 16'sd23040)
            : signed'({1'b0, req_heading});
      end
   end

   // stage 1: zero check and half-turn pre-rotation
   hew_pkg::vec_type x1_ff, y1_ff;
   hew_pkg::ang_type z1_ff;
   hew_pkg::side_type side1_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         side1_ff.comp <= side0_ff.comp;
         side1_ff.zero <= side0_ff.zero || (east_ff == 0 && north_ff == 0);
         if (north_ff < 0) begin
            x1_ff <= -(hew_pkg::VecW'(north_ff) <<< 24);
            y1_ff <= -(hew_pkg::VecW'(east_ff) <<< 24);
            z1_ff <= (east_ff >= 0) ? 34'sd754974720 : -34'sd754974720;
         end else begin
            x1_ff <= hew_pkg::VecW'(north_ff) <<< 24;
            y1_ff <= hew_pkg::VecW'(east_ff) <<< 24;
            z1_ff <= '0;
         end
      end
   end

   hew_pkg::vec_type xs [Steps+1];
   hew_pkg::vec_type ys [Steps+1];
   hew_pkg::ang_type zs [Steps+1];
   hew_pkg::side_type ss [Steps+1];
   assign xs[0] = x1_ff;
   assign ys[0] = y1_ff;
   assign zs[0] = z1_ff;
   assign ss[0] = side1_ff;

   for (genvar i = 0; i < Steps; i++) begin : g_step
      hew_cordic_stage #(.Step(i)) u_stage (
         .clock(clock), .enable(enable),
         .x_in(xs[i]), .y_in(ys[i]), .z_in(zs[i]), .side_in(ss[i]),
         .x_out(xs[i+1]), .y_out(ys[i+1]), .z_out(zs[i+1]), .side_out(ss[i+1])
      );
   end

   // final stage: round, clamp, wrap
   hew_pkg::ang_type rnd;
   logic signed [17:0] ang, diff, mag, res;
   logic signed [14:0] out_ff;
   always_comb begin
      rnd = (zs[Steps] + 34'sd32768) >>> 16;
      if (rnd > 34'sd11520) ang = 18'sd11520;
      else if (rnd < -34'sd11520) ang = -18'sd11520;
      else ang = 18'(rnd);
      diff = ang - 18'(ss[Steps].comp);
      mag = (diff < 0) ? -diff : diff;
      if (mag > 18'sd11520) res = (ang < 0) ? 18'sd23040 - mag : mag - 18'sd23040;
      else res = diff;
   end
   always_ff @(posedge clock) begin
      if (enable) begin
         out_ff <= ss[Steps].zero ? '0 : 15'(res);
      end
   end
   assign rsp_turn_error = out_ff;

`ifndef SYNTH
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_turn_error))
      else $error("result changed under stall");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_turn_error >= -15'sd11520 && rsp_turn_error <= 15'sd11520)
      else $error("turn error out of range");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("ready mismatch");
`endif
endmodule
`default_nettype wire

// ===== design/hew_cordic_stage.sv =====
`default_nettype none
module hew_cordic_stage #(
   parameter int Step = 0
) (
   input  wire logic               clock,
   input  wire logic               enable,
   input  wire hew_pkg::vec_type   x_in,
   input  wire hew_pkg::vec_type   y_in,
   input  wire hew_pkg::ang_type   z_in,
   input  wire hew_pkg::side_type  side_in,
   output hew_pkg::vec_type        x_out,
   output hew_pkg::vec_type        y_out,
   output hew_pkg::ang_type        z_out,
   output hew_pkg::side_type       side_out
);
   hew_pkg::vec_type x_ff, y_ff, xs, ys;
   hew_pkg::ang_type z_ff, at;
   hew_pkg::side_type side_ff;

   assign xs = x_in >>> Step;
   assign ys = y_in >>> Step;
   assign at = hew_pkg::atan_entry(5'(Step));

   always_ff @(posedge clock) begin
      if (enable) begin
         side_ff <= side_in;
         if (y_in > 0) begin
            x_ff <= x_in + ys;
            y_ff <= y_in - xs;
            z_ff <= z_in + at;
         end else begin
            x_ff <= x_in - ys;
            y_ff <= y_in + xs;
            z_ff <= z_in - at;
         end
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;
   assign side_out = side_ff;
endmodule
`default_nettype wire
